@@ design/adbdev_pkg.sv @@
// adbdev_pkg: shared types, phase, event and config register codes for the desktop bus device interface
// depends on nothing
`timescale 1ns / 1ps
package adbdev_pkg;
	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_CMD = 3'd1;
	localparam logic [2:0] EV_RESET = 3'd2;
	localparam logic [2:0] EV_ERROR = 3'd3;
	localparam logic [2:0] EV_COLL = 3'd4;
	localparam logic [2:0] EV_LISTEN = 3'd5;
	localparam logic [2:0] EV_BUSY = 3'd6;

	localparam logic [4:0] PH_IDLE = 5'd0;
	localparam logic [4:0] PH_ATTN = 5'd1;
	localparam logic [4:0] PH_SYNC = 5'd2;
	localparam logic [4:0] PH_CLOW = 5'd3;
	localparam logic [4:0] PH_CHIGH = 5'd4;
	localparam logic [4:0] PH_STOPW = 5'd5;
	localparam logic [4:0] PH_SRQ = 5'd6;
	localparam logic [4:0] PH_TXGAP = 5'd7;
	localparam logic [4:0] PH_TXLOW = 5'd8;
	localparam logic [4:0] PH_TXHIGH = 5'd9;
	localparam logic [4:0] PH_LGAP = 5'd10;
	localparam logic [4:0] PH_LSLOW = 5'd11;
	localparam logic [4:0] PH_LSHIGH = 5'd12;
	localparam logic [4:0] PH_LLOW = 5'd13;
	localparam logic [4:0] PH_LHIGH = 5'd14;
	localparam logic [4:0] PH_LSTOP = 5'd15;

	localparam logic [1:0] REG_MOUSE_ADDR = 2'd0;
	localparam logic [1:0] REG_KBD_ADDR = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic [13:0] TIMER_MAX = 14'd16383;

	typedef struct packed {
		logic       line_level;
		logic       service_request;
		logic [3:0] random_id;
	} in_item_t;

	typedef struct packed {
		logic        drive_low;
		logic [2:0]  event_res;
		logic [7:0]  command_byte;
		logic [15:0] listen_word;
		logic [3:0]  mouse_address;
		logic [3:0]  keyboard_address;
	} out_item_t;
endpackage

@@ design/adb_device_bus_interface_unit.sv @@
// adb_device_bus_interface_unit: device side of a one-wire desktop bus
// (mouse and keyboard functions); depends on adbdev_pkg
`timescale 1ns / 1ps
// usage
// - in channel: one transfer per microsecond tick carrying the sampled data
//   line, the service request flag and a random id for the identity reply
// - out channel: exactly one result transfer per input transfer, holding the
//   line drive, the event code, last command, last listen word and addresses
// - config port: cfg_we, cfg_index, cfg_data; write only when idle
// timing and throughput
// - the tick is processed in the cycle it is accepted; its result sits in
//   the output register from the next cycle
// - one transfer per cycle is sustained while out_ready is high: the phase
//   machine, pulse timer and shift register all update in a single pass of compare logic
// reset
// - arst_n clears the phase machine to idle, timer and shift state to zero,
//   config to 3 / 2 / 10000 and addresses to the reset addresses
// stall
// - when out_ready is low and a result is held, in_ready drops; a one-entry
//   output register parts the channels so a taken result frees it at once
module adb_device_bus_interface_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  adbdev_pkg::in_item_t    in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output adbdev_pkg::out_item_t   out_data,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [13:0]             cfg_data
);
	// configuration registers
	logic [3:0]  mouse_rst_q, kbd_rst_q;
	logic [13:0] timeout_q;
	// model state
	logic [4:0]  phase_q;
	logic [13:0] timer_q, low_len_q;
	logic        prev_q;
	logic [15:0] shift_q;
	logic [4:0]  bits_q;
	logic [7:0]  cmd_q;
	logic [15:0] listen_q;
	logic [3:0]  maddr_q, kaddr_q;

	logic [4:0]  phase_d;
	logic [13:0] timer_d, low_len_d;
	logic [15:0] shift_d;
	logic [4:0]  bits_d;
	logic [7:0]  cmd_d;
	logic [15:0] listen_d;
	logic [3:0]  maddr_d, kaddr_d;
	logic [2:0]  ev;
	logic        drive;

	logic accept;
	assign in_ready = !out_valid || out_ready;
	assign accept = in_valid && in_ready;

	// single-pass tick logic
	logic        lvl, edge_seen, tout;
	logic [13:0] dur, ttick;
	logic [6:0]  tx_low;
	logic [4:0]  tx_sub;
	logic [3:0]  tx_idx;
	logic [15:0] shift_in;
	logic [3:0]  rid15;
	logic [3:0]  c_addr, n_addr;
	logic        is_m, is_k;

	always_comb begin
		lvl = in_data.line_level;
		edge_seen = lvl != prev_q;
		dur = timer_q;
		tout = 1'b0;
		phase_d = phase_q;
		timer_d = timer_q;
		low_len_d = low_len_q;
		shift_d = shift_q;
		bits_d = bits_q;
		cmd_d = cmd_q;
		listen_d = listen_q;
		maddr_d = maddr_q;
		kaddr_d = kaddr_q;
		ev = adbdev_pkg::EV_NONE;
		drive = 1'b0;
		// low time of the bit in flight while transmitting
		tx_sub = 5'd16 - bits_q;
		tx_idx = tx_sub[3:0];
		if (bits_q == 5'd0) tx_low = 7'd35;
		else if (bits_q >= 5'd17) tx_low = 7'd65;
		else tx_low = shift_q[tx_idx] ? 7'd35 : 7'd65;
		shift_in = {shift_q[14:0], (dur > low_len_q)};
		rid15 = (in_data.random_id == 4'd15) ? 4'd0 : in_data.random_id;
		c_addr = shift_q[7:4];
		is_m = c_addr == maddr_q;
		is_k = c_addr == kaddr_q;
		n_addr = shift_q[11:8];
		ttick = timer_q + 14'd1;

		// pulse timer runs except in the service request and transmit phases
		if (phase_q != adbdev_pkg::PH_SRQ && phase_q != adbdev_pkg::PH_TXGAP &&
				phase_q != adbdev_pkg::PH_TXLOW && phase_q != adbdev_pkg::PH_TXHIGH) begin
			if (edge_seen) timer_d = 14'd1;
			else begin
				tout = timer_q >= timeout_q;
				if (timer_q < adbdev_pkg::TIMER_MAX) timer_d = ttick;
			end
		end

		unique case (phase_q)
			adbdev_pkg::PH_IDLE: begin
				if (edge_seen && !lvl) phase_d = adbdev_pkg::PH_ATTN;
			end
			adbdev_pkg::PH_ATTN: begin
				if (edge_seen) begin
					if (dur > 14'd2000) ev = adbdev_pkg::EV_RESET;
					else if (dur < 14'd600) begin
						ev = adbdev_pkg::EV_BUSY;
						phase_d = adbdev_pkg::PH_IDLE;
					end else phase_d = adbdev_pkg::PH_SYNC;
				end else if (tout) ev = adbdev_pkg::EV_RESET;
				if (ev == adbdev_pkg::EV_RESET) begin
					maddr_d = mouse_rst_q;
					kaddr_d = kbd_rst_q;
					phase_d = adbdev_pkg::PH_IDLE;
				end
			end
			adbdev_pkg::PH_SYNC: begin
				if (edge_seen) begin
					if (dur > 14'd90 || dur < 14'd50) begin
						ev = adbdev_pkg::EV_ERROR;
						phase_d = adbdev_pkg::PH_IDLE;
					end else begin
						phase_d = adbdev_pkg::PH_CLOW;
						bits_d = 5'd0;
						shift_d = 16'd0;
					end
				end else if (tout) begin
					ev = adbdev_pkg::EV_ERROR;
					phase_d = adbdev_pkg::PH_IDLE;
				end
			end
			adbdev_pkg::PH_CLOW, adbdev_pkg::PH_LLOW: begin
				if (edge_seen) begin
					low_len_d = dur;
					phase_d = (phase_q == adbdev_pkg::PH_CLOW) ?
						adbdev_pkg::PH_CHIGH : adbdev_pkg::PH_LHIGH;
				end else if (tout) begin
					ev = adbdev_pkg::EV_ERROR;
					phase_d = adbdev_pkg::PH_IDLE;
				end
			end
			adbdev_pkg::PH_CHIGH, adbdev_pkg::PH_LHIGH: begin
				if (edge_seen) begin
					shift_d = shift_in;
					bits_d = bits_q + 5'd1;
					if (bits_d >= ((phase_q == adbdev_pkg::PH_CHIGH) ? 5'd8 : 5'd16)) begin
						if (phase_q == adbdev_pkg::PH_LHIGH) phase_d = adbdev_pkg::PH_LSTOP;
						else if (in_data.service_request) begin
							phase_d = adbdev_pkg::PH_SRQ;
							timer_d = 14'd0;
						end else phase_d = adbdev_pkg::PH_STOPW;
					end else begin
						phase_d = (phase_q == adbdev_pkg::PH_CHIGH) ?
							adbdev_pkg::PH_CLOW : adbdev_pkg::PH_LLOW;
					end
				end else if (tout) begin
					ev = adbdev_pkg::EV_ERROR;
					phase_d = adbdev_pkg::PH_IDLE;
				end
			end
			adbdev_pkg::PH_STOPW, adbdev_pkg::PH_SRQ: begin
				if (phase_q == adbdev_pkg::PH_SRQ && timer_q < 14'd300) begin
					drive = 1'b1;
					timer_d = ttick;
				end else if (phase_q == adbdev_pkg::PH_SRQ || edge_seen || tout) begin
					// command complete: mouse wins on equal addresses
					ev = adbdev_pkg::EV_CMD;
					cmd_d = shift_q[7:0];
					phase_d = adbdev_pkg::PH_IDLE;
					if (c_addr != 4'd0 && shift_q[1:0] == 2'd3 && (is_m || is_k)) begin
						if (shift_q[3:2] == 2'd3) begin
							shift_d = (is_m ? 16'h6001 : 16'h6005) | {4'd0, rid15, 8'd0};
							phase_d = adbdev_pkg::PH_TXGAP;
							timer_d = 14'd0;
						end else if (shift_q[3:2] == 2'd2) begin
							phase_d = adbdev_pkg::PH_LGAP;
							timer_d = 14'd0;
						end
					end
				end
			end
			adbdev_pkg::PH_TXGAP: begin
				timer_d = ttick;
				if (ttick >= 14'd170) begin
					phase_d = adbdev_pkg::PH_TXLOW;
					timer_d = 14'd0;
					bits_d = 5'd0;
				end
			end
			adbdev_pkg::PH_TXLOW: begin
				drive = 1'b1;
				timer_d = ttick;
				if (ttick >= {7'd0, tx_low}) begin
					timer_d = 14'd0;
					phase_d = (bits_q >= 5'd17) ? adbdev_pkg::PH_IDLE : adbdev_pkg::PH_TXHIGH;
				end
			end
			adbdev_pkg::PH_TXHIGH: begin
				if (timer_q == 14'd0 && bits_q >= 5'd1 && bits_q <= 5'd16 && !lvl) begin
					ev = adbdev_pkg::EV_COLL;
					phase_d = adbdev_pkg::PH_IDLE;
				end else begin
					timer_d = ttick;
					if (ttick >= {7'd0, 7'd100 - tx_low}) begin
						timer_d = 14'd0;
						bits_d = bits_q + 5'd1;
						phase_d = adbdev_pkg::PH_TXLOW;
					end
				end
			end
			adbdev_pkg::PH_LGAP: begin
				if (!prev_q || tout) begin
					ev = adbdev_pkg::EV_ERROR;
					phase_d = adbdev_pkg::PH_IDLE;
				end else if (edge_seen) phase_d = adbdev_pkg::PH_LSLOW;
			end
			adbdev_pkg::PH_LSLOW: begin
				if (edge_seen) phase_d = adbdev_pkg::PH_LSHIGH;
				else if (tout) begin
					ev = adbdev_pkg::EV_ERROR;
					phase_d = adbdev_pkg::PH_IDLE;
				end
			end
			adbdev_pkg::PH_LSHIGH: begin
				if (edge_seen) begin
					phase_d = adbdev_pkg::PH_LLOW;
					bits_d = 5'd0;
					shift_d = 16'd0;
				end else if (tout) begin
					ev = adbdev_pkg::EV_ERROR;
					phase_d = adbdev_pkg::PH_IDLE;
				end
			end
			adbdev_pkg::PH_LSTOP: begin
				if (edge_seen || tout) begin
					ev = adbdev_pkg::EV_LISTEN;
					listen_d = shift_q;
					phase_d = adbdev_pkg::PH_IDLE;
					if (shift_q[7:1] == 7'h7F) begin
						if (cmd_q[7:4] == maddr_q) maddr_d = n_addr;
						else kaddr_d = n_addr;
					end
				end
			end
			default: phase_d = adbdev_pkg::PH_IDLE;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mouse_rst_q <= 4'd3;
			kbd_rst_q <= 4'd2;
			timeout_q <= 14'd10000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adbdev_pkg::REG_MOUSE_ADDR: mouse_rst_q <= cfg_data[3:0];
				adbdev_pkg::REG_KBD_ADDR: kbd_rst_q <= cfg_data[3:0];
				adbdev_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// state update, one tick per accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= adbdev_pkg::PH_IDLE;
			timer_q <= 14'd0;
			low_len_q <= 14'd0;
			prev_q <= 1'b1;
			shift_q <= 16'd0;
			bits_q <= 5'd0;
			cmd_q <= 8'd0;
			listen_q <= 16'd0;
			maddr_q <= 4'd3;
			kaddr_q <= 4'd2;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				timer_q <= timer_d;
				low_len_q <= low_len_d;
				prev_q <= lvl;
				shift_q <= shift_d;
				bits_q <= bits_d;
				cmd_q <= cmd_d;
				listen_q <= listen_d;
				maddr_q <= maddr_d;
				kaddr_q <= kaddr_d;
			end
			if (accept) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data.drive_low <= drive;
			out_data.event_res <= ev;
			out_data.command_byte <= cmd_d;
			out_data.listen_word <= listen_d;
			out_data.mouse_address <= maddr_d;
			out_data.keyboard_address <= kaddr_d;
		end
	end

	// a result is never dropped while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result lost under stall");
	// no input taken while a stalled result waits
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted over stalled result");
	// line is driven only in driving phases
	a_drive: assert property (@(posedge clk) disable iff (!arst_n)
		accept && drive |-> (phase_q == adbdev_pkg::PH_SRQ || phase_q == adbdev_pkg::PH_TXLOW))
		else $error("line driven outside a driving phase");
endmodule
